### rtl/adc_frame_parser_crc16_assert.svh
// Assertion macros shared by the frame parser RTL.
`ifndef ADC_FRAME_PARSER_CRC16_ASSERT_SVH
`define ADC_FRAME_PARSER_CRC16_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define AFP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define AFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/afp_pkg.sv
// Constants, types and CRC helpers for the ADC frame parser.
`timescale 1ns / 1ps
`default_nettype none

package afp_pkg;

   localparam int unsigned POS_WIDTH = 5;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_TOPBIT = 16'h8000;

   // Byte positions inside the 18-byte frame.
   localparam logic [POS_WIDTH-1:0] POS_FIRST     = 5'd0;
   localparam logic [POS_WIDTH-1:0] POS_STATUS_LO = 5'd1;
   localparam logic [POS_WIDTH-1:0] POS_CRC_BYTES = 5'd15;
   localparam logic [POS_WIDTH-1:0] POS_CRC_HI    = 5'd15;
   localparam logic [POS_WIDTH-1:0] POS_CRC_LO    = 5'd16;
   localparam logic [POS_WIDTH-1:0] POS_LAST      = 5'd17;

   typedef logic [POS_WIDTH-1:0] pos_type;
   typedef logic [23:0]          sample_type;

   // One byte of CRC-16/CCITT-FALSE, MSB first, unrolled over eight bits.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOPBIT) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Channel slot for sample bytes at positions 3 to 14, three bytes each.
   function automatic logic [1:0] chan_index(input pos_type pos);
      logic [1:0] ch;
      case (pos) inside
         [5'd3:5'd5]:   ch = 2'd0;
         [5'd6:5'd8]:   ch = 2'd1;
         [5'd9:5'd11]:  ch = 2'd2;
         [5'd12:5'd14]: ch = 2'd3;
         default:       ch = 2'd0;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

### rtl/adc_frame_parser_crc16.sv
// Top level of the ADC frame parser with CRC-16 frame check.
// Flow: a byte is taken into the input register and processed from there when it
// advances; byte 17 then loads the result register and is shown on rsp_valid.
// Throughput: one byte per cycle with a byte-wide CRC update, while no result waits untaken.
// Reset: synchronous and active high; clears the byte count, sets the CRC to all
// ones, clears the held fields and empties the input and result registers.
`timescale 1ns / 1ps
`default_nettype none

module adc_frame_parser_crc16 (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_frame_start,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_status_word,
   output logic signed [23:0]      rsp_channel_zero,
   output logic signed [23:0]      rsp_channel_one,
   output logic signed [23:0]      rsp_channel_two,
   output logic signed [23:0]      rsp_channel_three,
   output logic                    rsp_crc_match
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_start_ff;

   // Frame state.
   afp_pkg::pos_type    pos_ff, pos_in;
   logic [15:0]         crc_ff, crc_in;
   logic [15:0]         status_ff, status_in;
   afp_pkg::sample_type sample_ff [4];
   afp_pkg::sample_type sample_in [4];
   logic [15:0]         rx_crc_ff, rx_crc_in;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   logic [15:0]         out_status_ff;
   logic signed [23:0]  out_ch0_ff, out_ch1_ff, out_ch2_ff, out_ch3_ff;
   logic                out_match_ff;

   logic             advance;
   logic             is_last;
   afp_pkg::pos_type pos_cur;
   logic [1:0]       ch;

   // The held byte moves on when the result register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Effective position: frame start or an out-of-range count restarts at byte 0.
   always_comb begin
      if (in_start_ff || (pos_ff > afp_pkg::POS_LAST)) begin
         pos_cur = afp_pkg::POS_FIRST;
      end else begin
         pos_cur = pos_ff;
      end
   end

   assign is_last = (pos_cur == afp_pkg::POS_LAST);
   assign ch      = afp_pkg::chan_index(pos_cur);

   // Next frame state for the held byte.
   always_comb begin
      logic [15:0] crc_base;
      crc_base  = (pos_cur == afp_pkg::POS_FIRST) ? afp_pkg::CRC_INIT : crc_ff;
      crc_in    = crc_base;
      status_in = status_ff;
      rx_crc_in = rx_crc_ff;
      for (int i = 0; i < 4; i++) begin
         sample_in[i] = sample_ff[i];
      end
      if (pos_cur < afp_pkg::POS_CRC_BYTES) begin
         crc_in = afp_pkg::crc_byte(crc_base, in_data_ff);
      end
      if (pos_cur <= afp_pkg::POS_STATUS_LO) begin
         status_in = {status_ff[7:0], in_data_ff};
      end else if (pos_cur >= 5'd3 && pos_cur < afp_pkg::POS_CRC_BYTES) begin
         sample_in[ch] = {sample_ff[ch][15:0], in_data_ff};
      end else if (pos_cur == afp_pkg::POS_CRC_HI || pos_cur == afp_pkg::POS_CRC_LO) begin
         rx_crc_in = {rx_crc_ff[7:0], in_data_ff};
      end
      pos_in = is_last ? afp_pkg::POS_FIRST : pos_cur + 5'd1;
   end

   // Result valid: set by the last byte of a frame, cleared when taken.
   always_comb begin
      if (advance && is_last) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Control and frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= afp_pkg::POS_FIRST;
         crc_ff       <= afp_pkg::CRC_INIT;
         status_ff    <= '0;
         rx_crc_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            sample_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pos_ff    <= pos_in;
            crc_ff    <= crc_in;
            status_ff <= status_in;
            rx_crc_ff <= rx_crc_in;
            for (int i = 0; i < 4; i++) begin
               sample_ff[i] <= sample_in[i];
            end
         end
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
      end
   end

   // Result payload register, loaded by the last byte of a frame.
   always_ff @(posedge clock) begin
      if (advance && is_last) begin
         out_status_ff <= status_ff;
         out_ch0_ff    <= sample_ff[0];
         out_ch1_ff    <= sample_ff[1];
         out_ch2_ff    <= sample_ff[2];
         out_ch3_ff    <= sample_ff[3];
         out_match_ff  <= (crc_ff == rx_crc_ff);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status_word   = out_status_ff;
   assign rsp_channel_zero  = out_ch0_ff;
   assign rsp_channel_one   = out_ch1_ff;
   assign rsp_channel_two   = out_ch2_ff;
   assign rsp_channel_three = out_ch3_ff;
   assign rsp_crc_match     = out_match_ff;

   // Checks on the byte count, the input register and the stall logic.
`include "adc_frame_parser_crc16_assert.svh"

   `AFP_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= afp_pkg::POS_LAST, "byte count out of range")

   `AFP_ASSERT_NEXT(a_wrap_after_last, advance && is_last, pos_ff == afp_pkg::POS_FIRST,
      "byte count did not wrap after the last byte")

   `AFP_ASSERT_NEXT(a_hold_when_stalled, in_valid_ff && !advance,
      in_valid_ff && $stable(in_data_ff) && $stable(in_start_ff),
      "stalled item lost from the input register")

   `AFP_ASSERT_NOW(a_ready_when_empty, !in_valid_ff, req_ready,
      "input refused while the input register is empty")

   `AFP_ASSERT_NEXT(a_result_held, out_valid_ff && !rsp_ready,
      out_valid_ff && $stable(out_status_ff) && $stable(out_match_ff),
      "pending result overwritten")

endmodule

`default_nettype wire

### dv/adc_frame_parser_crc16_tb.sv
// Self-checking testbench for the ADC frame parser with CRC-16 frame check.
`timescale 1ns / 1ps

module adc_frame_parser_crc16_tb;

   localparam logic [15:0] CRC_SEED  = 16'hFFFF;
   localparam logic [15:0] CRC_GEN   = 16'h1021;
   localparam logic [4:0]  CRC_SPAN  = 5'd15;
   localparam logic [4:0]  CRC_HI    = 5'd15;
   localparam logic [4:0]  CRC_LO    = 5'd16;
   localparam logic [4:0]  TAIL_BYTE = 5'd17;
   localparam int          FRAME_LEN = 18;
   localparam int          MAX_SHOWN = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } byte_item_type;

   typedef struct packed {
      logic [15:0]                    status;
      logic [3:0][23:0]               chan;
      logic                           match;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_status_word;
   afp_pkg::sample_type rsp_channel_zero;
   afp_pkg::sample_type rsp_channel_one;
   afp_pkg::sample_type rsp_channel_two;
   afp_pkg::sample_type rsp_channel_three;
   logic rsp_crc_match;

   byte_item_type    bytes_to_send[$];
   frame_result_type frames_due[$];
   byte_item_type    next_item;
   bit               req_fire = 1'b0;
   int               drv_cycle = 0;
   int               err_count = 0;
   logic             calm;

   // Parser state mirrored for prediction.
   logic [4:0]       frame_pos;
   logic [15:0]      crc_acc;
   logic [15:0]      status_acc;
   logic [3:0][23:0] sample_acc;
   logic [15:0]      dev_crc;

   adc_frame_parser_crc16 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status_word   (rsp_status_word),
      .rsp_channel_zero  (rsp_channel_zero),
      .rsp_channel_one   (rsp_channel_one),
      .rsp_channel_two   (rsp_channel_two),
      .rsp_channel_three (rsp_channel_three),
      .rsp_crc_match     (rsp_crc_match)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Both sides run without idling for a stretch in every window.
   assign calm = ((drv_cycle % 2400) >= 600) && ((drv_cycle % 2400) < 1400);

   // CRC-16/CCITT-FALSE over one byte, processed one data bit at a time.
   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_GEN;
         end
      end
      return c;
   endfunction

   // Track one accepted byte through the frame and queue the result on the tail byte.
   task automatic advance_frame(input logic [7:0] b, input logic start);
      logic [4:0]       pos;
      int               ch;
      frame_result_type r;
      pos = start ? 5'd0 : frame_pos;
      if (pos > TAIL_BYTE) begin
         pos = 5'd0;
      end
      if (pos == 5'd0) begin
         crc_acc = CRC_SEED;
      end
      if (pos < CRC_SPAN) begin
         crc_acc = crc_ccitt_step(crc_acc, b);
      end
      if (pos <= 5'd1) begin
         status_acc = {status_acc[7:0], b};
      end else if (pos >= 5'd3 && pos < CRC_SPAN) begin
         ch = (int'(pos) - 3) / 3;
         sample_acc[ch] = {sample_acc[ch][15:0], b};
      end else if (pos == CRC_HI || pos == CRC_LO) begin
         dev_crc = {dev_crc[7:0], b};
      end else if (pos == TAIL_BYTE) begin
         r.status = status_acc;
         r.chan   = sample_acc;
         r.match  = (crc_acc == dev_crc);
         frames_due.push_back(r);
      end
      frame_pos = (pos >= TAIL_BYTE) ? 5'd0 : pos + 5'd1;
   endtask

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= MAX_SHOWN) begin
         $display("[%0t] ERROR: %s", $realtime, msg);
      end
   endtask

   // Sample value biased toward the signed extremes.
   function automatic logic [23:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'h800000;
         1: return 24'h7FFFFF;
         2: return 24'h000000;
         3: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // Queue the first len bytes of a frame; the CRC is corrupted when good_crc is clear.
   task automatic queue_frame(input logic [15:0] status, input logic [3:0][23:0] smp,
                              input bit good_crc, input bit start, input int len);
      logic [7:0]    fb[FRAME_LEN];
      logic [15:0]   c;
      byte_item_type it;
      fb[0] = status[15:8];
      fb[1] = status[7:0];
      fb[2] = 8'($urandom);
      for (int k = 0; k < 4; k++) begin
         fb[3 + 3*k] = smp[k][23:16];
         fb[4 + 3*k] = smp[k][15:8];
         fb[5 + 3*k] = smp[k][7:0];
      end
      c = CRC_SEED;
      for (int k = 0; k < 15; k++) begin
         c = crc_ccitt_step(c, fb[k]);
      end
      if (!good_crc) begin
         c = c ^ 16'($urandom_range(1, 16'hFFFF));
      end
      fb[15] = c[15:8];
      fb[16] = c[7:0];
      fb[17] = 8'($urandom);
      for (int k = 0; k < len; k++) begin
         it.data  = fb[k];
         it.start = (k == 0) ? start : 1'b0;
         bytes_to_send.push_back(it);
      end
   endtask

   // Reset, then release the block.
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Stimulus: a directed opening, random frames, then the drain and the verdict.
   initial begin
      logic [3:0][23:0] smp;
      bit               aligned;
      int               kind;
      byte_item_type    it;

      // A partial frame cut off by a new frame start, then a frame of extreme values.
      for (int k = 0; k < 4; k++) begin
         smp[k] = pick_sample();
      end
      queue_frame(16'h1234, smp, 1'b1, 1'b1, 3);
      smp[0] = 24'h800000;
      smp[1] = 24'h7FFFFF;
      smp[2] = 24'h000000;
      smp[3] = 24'hFFFFFF;
      queue_frame(16'hFFFF, smp, 1'b1, 1'b1, FRAME_LEN);
      aligned = 1'b1;

      // Mostly complete frames with random content, some cut short, some noise.
      while (bytes_to_send.size() < 1570) begin
         kind = $urandom_range(99);
         for (int k = 0; k < 4; k++) begin
            smp[k] = pick_sample();
         end
         if (kind < 72) begin
            queue_frame(($urandom_range(9) == 0) ? {16{1'($urandom)}} : 16'($urandom), smp,
                        $urandom_range(3) != 0, aligned ? 1'($urandom) : 1'b1, FRAME_LEN);
            aligned = 1'b1;
         end else if (kind < 90) begin
            queue_frame(16'($urandom), smp, 1'b1, 1'b1, $urandom_range(1, FRAME_LEN - 1));
            aligned = 1'b0;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               it.data  = 8'($urandom);
               it.start = ($urandom_range(3) == 0);
               bytes_to_send.push_back(it);
            end
            aligned = 1'b0;
         end
      end

      while (bytes_to_send.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (frames_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("** adc_frame_parser_crc16: PASSED **");
      end else begin
         $display("** adc_frame_parser_crc16: FAILED **");
      end
      $finish;
   end

   // Driver: new items and ready change on the falling edge.
   always @(negedge clock) begin
      drv_cycle <= drv_cycle + 1;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
         if (!req_valid || req_fire) begin
            if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
               next_item = bytes_to_send.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= next_item.data;
               req_frame_start <= next_item.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: accepted bytes feed the prediction, accepted results are checked.
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      req_fire = 1'b0;
      if (reset) begin
         frame_pos  = 5'd0;
         crc_acc    = CRC_SEED;
         status_acc = 16'h0000;
         sample_acc = '0;
         dev_crc    = 16'h0000;
      end else begin
         if (req_valid && req_ready) begin
            req_fire = 1'b1;
            advance_frame(req_data_byte, req_frame_start);
         end
         if (rsp_valid && rsp_ready) begin
            got.status  = rsp_status_word;
            got.chan[0] = rsp_channel_zero;
            got.chan[1] = rsp_channel_one;
            got.chan[2] = rsp_channel_two;
            got.chan[3] = rsp_channel_three;
            got.match   = rsp_crc_match;
            if (frames_due.size() == 0) begin
               flag_error($sformatf("result with none expected: status %h crc_match %b",
                                    got.status, got.match));
            end else begin
               want = frames_due.pop_front();
               if (got.status !== want.status || got.chan[0] !== want.chan[0] ||
                   got.chan[1] !== want.chan[1] || got.chan[2] !== want.chan[2] ||
                   got.chan[3] !== want.chan[3] || got.match !== want.match) begin
                  flag_error($sformatf(
                     "exp st %h ch %0d %0d %0d %0d m %b, got st %h ch %0d %0d %0d %0d m %b",
                     want.status, $signed(want.chan[0]), $signed(want.chan[1]),
                     $signed(want.chan[2]), $signed(want.chan[3]), want.match,
                     got.status, $signed(got.chan[0]), $signed(got.chan[1]),
                     $signed(got.chan[2]), $signed(got.chan[3]), got.match));
               end
            end
         end
      end
   end

   // Watchdog for a hung handshake.
   initial begin
      #3000000;
      $display("** adc_frame_parser_crc16: FAILED **");
      $finish;
   end

endmodule
